// File: design/dq_pkg.sv
// Shared types and codes for the double-ended priority queue.
// No dependencies; imported by dq_cell, double_ended_priority_queue_top and the testbench.
package dq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MAX = 2'd1,
    OP_POP_MIN = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int OCC_W = 5;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic exec;
    op_t  op;
    logic full;
  } ctl_t;

endpackage

// File: design/dq_cell.sv
// One slot of the sorted chain: holds an (id, priority) entry and swaps with
// its neighbors. Depends on dq_pkg for the control struct and operation codes.
module dq_cell #(
  parameter int ID_BITS  = 16,
  parameter int PRI_BITS = 8,
  parameter int CNT_W    = 5,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  dq_pkg::ctl_t        ctl,
  input  logic [CNT_W-1:0]    count,
  input  logic [ID_BITS-1:0]  key_id,
  input  logic [PRI_BITS-1:0] key_pri,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic [PRI_BITS-1:0] left_pri,
  input  logic                left_ahead,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic [PRI_BITS-1:0] right_pri,
  input  logic                seen_in,
  input  logic [ID_BITS-1:0]  acc_id_in,
  input  logic [PRI_BITS-1:0] acc_pri_in,
  output logic [ID_BITS-1:0]  my_id,
  output logic [PRI_BITS-1:0] my_pri,
  output logic                ahead,
  output logic                seen_out,
  output logic [ID_BITS-1:0]  acc_id_out,
  output logic [PRI_BITS-1:0] acc_pri_out
);
  import dq_pkg::*;

  logic [ID_BITS-1:0]  id;
  logic [PRI_BITS-1:0] pri;
  logic                valid;
  logic                tail;
  logic                match;
  logic                sel;

  assign valid = (count > CNT_W'(IDX));
  assign tail  = (count == CNT_W'(IDX + 1));
  assign match = valid && (id == key_id);
  assign ahead = valid && ((pri > key_pri) || ((pri == key_pri) && (id < key_id)));

  assign seen_out = seen_in | match;

  // This cell hands its entry out when it is the one being removed.
  always_comb begin
    case (ctl.op)
      OP_POP_MAX: sel = valid && (IDX == 0);
      OP_POP_MIN: sel = tail;
      OP_REMOVE:  sel = match && !seen_in;
      default:    sel = 1'b0;
    endcase
  end

  assign acc_id_out  = acc_id_in  | (sel ? id  : '0);
  assign acc_pri_out = acc_pri_in | (sel ? pri : '0);

  assign my_id  = id;
  assign my_pri = pri;

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      case (ctl.op)
        OP_INSERT: begin
          if (!ctl.full && !ahead) begin
            id  <= left_ahead ? key_id  : left_id;
            pri <= left_ahead ? key_pri : left_pri;
          end
        end
        OP_POP_MAX: begin
          id  <= right_id;
          pri <= right_pri;
        end
        OP_REMOVE: begin
          if (seen_out) begin
            id  <= right_id;
            pri <= right_pri;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/double_ended_priority_queue_top.sv
// Double-ended priority queue built as a chain of sorted cells.
// A word accepted while idle is captured, run through the cell chain in the
// execute state, and its result is registered and strobed on done. busy is
// high in the execute state, so a new word is taken only once it has ended.
// Reset (rst, synchronous, active high) empties the queue; no clearing pass.
// The receiver cannot stall: each result is strobed on done for exactly one cycle.
module double_ended_priority_queue_top #(
  parameter int DEPTH         = 16,
  parameter int ID_BITS       = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation,
  input  logic [ID_BITS-1:0]       entry_id,
  input  logic [PRIORITY_BITS-1:0] entry_priority,
  output logic                     done,
  output logic [1:0]               status,
  output logic [ID_BITS-1:0]       removed_id,
  output logic [PRIORITY_BITS-1:0] removed_priority,
  output logic [dq_pkg::OCC_W-1:0] occupancy
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Word captured at accept time and held through the execute cycle.
  op_t                     op;
  logic [ID_BITS-1:0]      key_id;
  logic [PRIORITY_BITS-1:0] key_pri;

  // Number of valid entries; cell i holds a live entry when i < count.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             empty;
  logic             found;
  status_t          status_next;
  ctl_t             ctl;

  // Neighbor wiring of the chain. Index DEPTH of the right-hand arrays is the
  // phantom slot past the tail, whose contents never matter.
  logic [ID_BITS-1:0]       cell_id  [DEPTH+1];
  logic [PRIORITY_BITS-1:0] cell_pri [DEPTH+1];
  logic [DEPTH:0]           ahead_chain;
  logic [DEPTH:0]           seen_chain;
  logic [ID_BITS-1:0]       acc_id   [DEPTH+1];
  logic [PRIORITY_BITS-1:0] acc_pri  [DEPTH+1];

  assign busy  = (state == S_EXEC);
  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  assign ctl.exec = (state == S_EXEC);
  assign ctl.op   = op;
  assign ctl.full = full;

  // The head cell sees a virtual "ahead" neighbor, so an insert that beats
  // every held entry lands in slot zero. Nothing has matched before the head
  // and the result accumulators start empty.
  assign ahead_chain[0] = 1'b1;
  assign seen_chain[0]  = 1'b0;
  assign acc_id[0]      = '0;
  assign acc_pri[0]     = '0;
  assign cell_id[DEPTH]  = key_id;
  assign cell_pri[DEPTH] = key_pri;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]       left_id;
    logic [PRIORITY_BITS-1:0] left_pri;

    if (i == 0) begin : g_head
      assign left_id  = key_id;
      assign left_pri = key_pri;
    end else begin : g_body
      assign left_id  = cell_id[i-1];
      assign left_pri = cell_pri[i-1];
    end

    dq_cell #(
      .ID_BITS  (ID_BITS),
      .PRI_BITS (PRIORITY_BITS),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .key_id      (key_id),
      .key_pri     (key_pri),
      .left_id     (left_id),
      .left_pri    (left_pri),
      .left_ahead  (ahead_chain[i]),
      .right_id    (cell_id[i+1]),
      .right_pri   (cell_pri[i+1]),
      .seen_in     (seen_chain[i]),
      .acc_id_in   (acc_id[i]),
      .acc_pri_in  (acc_pri[i]),
      .my_id       (cell_id[i]),
      .my_pri      (cell_pri[i]),
      .ahead       (ahead_chain[i+1]),
      .seen_out    (seen_chain[i+1]),
      .acc_id_out  (acc_id[i+1]),
      .acc_pri_out (acc_pri[i+1])
    );
  end

  // A match anywhere along the chain means remove-by-id succeeds.
  assign found = seen_chain[DEPTH];

  // Status and new fill level for the operation being executed.
  always_comb begin
    count_next  = count;
    status_next = ST_MISS;
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_POP_MAX, OP_POP_MIN: begin
        if (!empty) begin
          status_next = ST_OK;
          count_next  = count - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          status_next = ST_OK;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: capture a word, then run it through the chain in the execute
  // state and strobe the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          count <= count_next;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op      <= op_t'(operation);
      key_id  <= entry_id;
      key_pri <= entry_priority;
    end
    if (state == S_EXEC) begin
      status           <= status_next;
      removed_id       <= acc_id[DEPTH];
      removed_priority <= acc_pri[DEPTH];
      occupancy        <= OCC_W'(count_next);
    end
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for double_ended_priority_queue_top.
// Depends on dq_pkg for the operation and status codes. It drives words
// through the start/busy port and checks every strobed result against a
// sorted-queue predictor.
`timescale 1ns / 1ps

module testbench;
  import dq_pkg::*;

  localparam int DEPTH  = 16;
  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int N_RAND = 630;

  // One word sent to the block.
  typedef struct {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } request_t;

  // One result the block is expected to strobe.
  typedef struct {
    status_t          st;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [OCC_W-1:0] occ;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       operation = OP_INSERT;
  logic [ID_W-1:0]  entry_id = '0;
  logic [PRI_W-1:0] entry_priority = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [ID_W-1:0]  removed_id;
  logic [PRI_W-1:0] removed_priority;
  logic [OCC_W-1:0] occupancy;

  request_t queued_requests[$];
  outcome_t expected_outcomes[$];
  int       mismatches = 0;
  int       accepted_words = 0;

  // Shadow copy of the queue contents: index 0 is the head (highest priority).
  logic [ID_W-1:0]  held_id[DEPTH];
  logic [PRI_W-1:0] held_pri[DEPTH];
  int               held_count = 0;

  double_ended_priority_queue_top #(
    .DEPTH(DEPTH),
    .ID_BITS(ID_W),
    .PRIORITY_BITS(PRI_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .entry_id(entry_id),
    .entry_priority(entry_priority),
    .done(done),
    .status(status),
    .removed_id(removed_id),
    .removed_priority(removed_priority),
    .occupancy(occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Removes the entry at pos, closing the gap, and returns it in the outcome.
  function automatic outcome_t extract_entry(int pos);
    outcome_t o;
    o.st  = ST_OK;
    o.id  = held_id[pos];
    o.pri = held_pri[pos];
    for (int k = pos; k + 1 < held_count; k++) begin
      held_id[k]  = held_id[k + 1];
      held_pri[k] = held_pri[k + 1];
    end
    held_count--;
    return o;
  endfunction

  // Applies one word to the shadow queue and returns the result it must produce.
  function automatic outcome_t apply_to_sorted_queue(request_t r);
    outcome_t o;
    int       pos;
    o.st  = ST_MISS;
    o.id  = '0;
    o.pri = '0;
    case (r.op)
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          o.st = ST_FULL;
        end else begin
          // The new entry lands in front of the first entry that has a lower
          // priority, or the same priority and an id not below its own, so an
          // identical entry already held ends up behind the new one.
          pos = 0;
          while (pos < held_count && (held_pri[pos] > r.pri ||
                 (held_pri[pos] == r.pri && held_id[pos] < r.id)))
            pos++;
          for (int k = held_count; k > pos; k--) begin
            held_id[k]  = held_id[k - 1];
            held_pri[k] = held_pri[k - 1];
          end
          held_id[pos]  = r.id;
          held_pri[pos] = r.pri;
          held_count++;
          o.st = ST_OK;
        end
      end
      OP_POP_MAX: begin
        if (held_count > 0) o = extract_entry(0);
      end
      OP_POP_MIN: begin
        if (held_count > 0) o = extract_entry(held_count - 1);
      end
      default: begin
        // Duplicate ids are legal; the match nearest the head goes.
        for (int k = 0; k < held_count; k++) begin
          if (held_id[k] == r.id) begin
            o = extract_entry(k);
            break;
          end
        end
      end
    endcase
    o.occ = OCC_W'(held_count);
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want,
             got);
    mismatches++;
  endtask

  task automatic add_request(op_t op, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    request_t r;
    r.op  = op;
    r.id  = id;
    r.pri = pri;
    queued_requests.push_back(r);
  endtask

  // Monitor and acceptance tracker. Results are checked before a new word is
  // predicted, so a result strobed at the same edge that another word is
  // taken is matched against the older expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          // A strobe with nothing outstanding is a spurious result.
          report_mismatch("done", 32'd0, 32'd1);
        end else begin
          want = expected_outcomes.pop_front();
          if (status !== want.st) report_mismatch("status", 32'(want.st), 32'(status));
          if (removed_id !== want.id)
            report_mismatch("removed_id", 32'(want.id), 32'(removed_id));
          if (removed_priority !== want.pri)
            report_mismatch("removed_priority", 32'(want.pri), 32'(removed_priority));
          if (occupancy !== want.occ)
            report_mismatch("occupancy", 32'(want.occ), 32'(occupancy));
        end
      end
      // A word is taken when start is high and busy is low at this edge; the
      // word on the pins is always the head of the pending queue.
      if (start === 1'b1 && busy === 1'b0) begin
        expected_outcomes.push_back(apply_to_sorted_queue(queued_requests.pop_front()));
        accepted_words++;
      end
    end
  end

  // Driver. Pins change only on the falling edge. Start is held low at random about
  // one time in ten, except for a stretch in the middle of the run where words are
  // offered back to back to keep the block saturated.
  always @(negedge clk) begin
    bit calm;
    calm = (accepted_words >= 250 && accepted_words < 400);
    if (rst || queued_requests.size() == 0 || (!calm && $urandom_range(0, 99) < 10)) begin
      start <= 1'b0;
    end else begin
      start          <= 1'b1;
      operation      <= queued_requests[0].op;
      entry_id       <= queued_requests[0].id;
      entry_priority <= queued_requests[0].pri;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int        insert_pct;
    int        pick;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;

    // Directed part: every operation on an empty queue first.
    add_request(OP_POP_MAX, '0, '0);
    add_request(OP_POP_MIN, '0, '0);
    add_request(OP_REMOVE, 16'h0007, '0);
    // Fill all sixteen slots, covering the field extremes, priority ties
    // broken by id, identical entries and the same id at two priorities.
    add_request(OP_INSERT, 16'h0000, 8'h00);
    add_request(OP_INSERT, 16'hFFFF, 8'hFF);
    add_request(OP_INSERT, 16'h0005, 8'h80);
    add_request(OP_INSERT, 16'h0003, 8'h80);
    add_request(OP_INSERT, 16'h0009, 8'h80);
    add_request(OP_INSERT, 16'h0003, 8'h80);
    add_request(OP_INSERT, 16'h0005, 8'h10);
    add_request(OP_INSERT, 16'hAAAA, 8'h55);
    add_request(OP_INSERT, 16'h5555, 8'hAA);
    add_request(OP_INSERT, 16'h0000, 8'hFF);
    add_request(OP_INSERT, 16'hFFFF, 8'h00);
    add_request(OP_INSERT, 16'h0001, 8'h01);
    add_request(OP_INSERT, 16'h8000, 8'h7F);
    add_request(OP_INSERT, 16'h7FFF, 8'hFE);
    add_request(OP_INSERT, 16'h0009, 8'h80);
    add_request(OP_INSERT, 16'h1234, 8'h40);
    // Insert into a full queue, then the removal cases.
    add_request(OP_INSERT, 16'h4321, 8'h99);
    add_request(OP_REMOVE, 16'hBEEF, '0);
    add_request(OP_REMOVE, 16'h0005, '0);
    add_request(OP_POP_MAX, '0, '0);
    add_request(OP_POP_MIN, '0, '0);

    // Random part, alternating fill-heavy and drain-heavy phases so the queue
    // swings between empty and full many times. Ids often come from a small
    // pool so removes find matches and duplicates build up.
    insert_pct = 25;
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 40 == 0) insert_pct = (insert_pct == 70) ? 25 : 70;
      id = ($urandom_range(0, 3) != 0) ? ID_W'($urandom_range(0, 15))
                                       : ID_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
        0:       pri = PRI_W'($urandom_range(0, 3));
        1:       pri = PRI_W'($urandom_range(0, 255));
        default: pri = PRI_W'(255 - $urandom_range(0, 2));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) add_request(OP_INSERT, id, pri);
      else case ($urandom_range(0, 2))
        0:       add_request(OP_POP_MAX, ID_W'($urandom), PRI_W'($urandom));
        1:       add_request(OP_POP_MIN, ID_W'($urandom), PRI_W'($urandom));
        default: add_request(OP_REMOVE, id, PRI_W'($urandom));
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Every word must be taken and answered; then the run waits on for any
    // stray result to show up.
    wait (queued_requests.size() == 0 && expected_outcomes.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_priority_queue_top.sv
tb/sv/testbench.sv
